@@ sv/rtse_pkg.sv @@
// ----------------------------------------------------------------------------
// rtse_pkg
// Shared types and constants for the record table search engine.
// ----------------------------------------------------------------------------
package rtse_pkg;

    localparam int DEPTH_DEF = 32;
    localparam logic [9:0] SCORE_MAX = 10'd1000;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_LINEAR = 3'd4,
        CMD_BINARY = 3'd5,
        CMD_MAX    = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE,
        S_LIN,
        S_BS_RD,
        S_BS_CMP,
        S_MAX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] kh;
        logic [63:0] kl;
        logic [9:0]  sc;
    } t_rec;

    typedef struct packed {
        logic [2:0] cmd;
        logic [15:0] kh;
        logic [63:0] kl;
        logic [9:0]  sc;
        logic [5:0]  pos;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic [4:0] slot_index;
        t_rec       rec;
        logic [5:0] entry_count;
    } t_result;

endpackage

@@ sv/rtse_mem.sv @@
// ----------------------------------------------------------------------------
// rtse_mem
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtse_mem #(
    parameter int DEPTH = rtse_pkg::DEPTH_DEF,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  rtse_pkg::t_rec  i_wdata,
    input  logic            i_re,
    input  logic [IW-1:0]   i_raddr,
    output rtse_pkg::t_rec  o_rdata
);

    rtse_pkg::t_rec r_mem [DEPTH];
    rtse_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rtse_ctrl.sv @@
// ----------------------------------------------------------------------------
// rtse_ctrl
// Command sequencer: walks the store one entry per cycle for shifts, linear
// search and max scan, bisects it for binary search; one result per command.
// ----------------------------------------------------------------------------
module rtse_ctrl #(
    parameter int DEPTH = rtse_pkg::DEPTH_DEF,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rtse_pkg::t_item   i_item,
    input  logic              i_out_free,
    output logic              o_done,
    output rtse_pkg::t_result o_result,
    output logic              o_mem_we,
    output logic [IW-1:0]     o_mem_waddr,
    output rtse_pkg::t_rec    o_mem_wdata,
    output logic              o_mem_re,
    output logic [IW-1:0]     o_mem_raddr,
    input  rtse_pkg::t_rec    i_mem_rdata
);

    localparam int PW = (CW > 6) ? CW : 6;

    rtse_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_pend, n_pend;
    logic             r_first, n_first;
    logic [CW-1:0]    r_left, n_left;
    logic [IW-1:0]    r_ra, n_ra;
    logic [IW-1:0]    r_wa, n_wa;
    logic [IW-1:0]    r_pidx, n_pidx;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hp1, n_hp1;
    logic [2:0]       r_cmd, n_cmd;
    rtse_pkg::t_rec   r_new, n_new;
    logic [5:0]       r_pos, n_pos;
    rtse_pkg::t_status r_status, n_status;
    logic [IW-1:0]    r_ridx, n_ridx;
    rtse_pkg::t_rec   r_rrec, n_rrec;

    logic [PW-1:0]    w_pos_x;
    logic [PW-1:0]    w_n_x;
    logic             w_pos_bad;
    logic             w_full;
    logic             w_empty;
    logic [IW-1:0]    w_pos_m1;
    logic             w_key_eq;
    logic             w_key_gt;
    logic             w_sc_gt;
    logic             w_lo_lt;
    logic [CW:0]      w_mid_sum;
    logic [IW-1:0]    w_mid;
    logic             w_walk_done;
    logic             w_accept;
    logic [IW+4:0]    w_idx_ext;
    logic [CW+5:0]    w_cnt_ext;
    logic [9:0]       w_sc_sat;

    assign w_accept  = i_valid && (r_state == rtse_pkg::S_IDLE);
    assign w_sc_sat  = (i_item.sc > rtse_pkg::SCORE_MAX) ? rtse_pkg::SCORE_MAX : i_item.sc;
    assign w_pos_x   = PW'(r_pos);
    assign w_n_x     = PW'(r_count);
    assign w_pos_bad = (r_pos == 6'd0) || (w_pos_x > w_n_x);
    assign w_full    = (r_count >= CW'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_pos_m1  = IW'(w_pos_x - PW'(1));
    assign w_key_eq  = ({i_mem_rdata.kh, i_mem_rdata.kl} == {r_new.kh, r_new.kl});
    assign w_key_gt  = ({i_mem_rdata.kh, i_mem_rdata.kl} > {r_new.kh, r_new.kl});
    assign w_sc_gt   = (i_mem_rdata.sc > r_rrec.sc);
    assign w_lo_lt   = (r_lo < r_hp1);
    assign w_mid_sum = (CW+1)'(r_lo) + (CW+1)'(r_hp1) - (CW+1)'(1);
    assign w_mid     = IW'(w_mid_sum >> 1);
    assign w_walk_done = (r_left == '0) && !r_pend;
    assign w_idx_ext = (IW+5)'(r_ridx);
    assign w_cnt_ext = (CW+6)'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rtse_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = rtse_pkg::S_DECODE;
                end
            end
            rtse_pkg::S_DECODE: begin
                case (r_cmd)
                    rtse_pkg::CMD_INSERT: begin
                        n_state = (w_pos_bad || w_full) ? rtse_pkg::S_DONE : rtse_pkg::S_MOVE;
                    end
                    rtse_pkg::CMD_DELETE: begin
                        n_state = (w_empty || w_pos_bad) ? rtse_pkg::S_DONE : rtse_pkg::S_MOVE;
                    end
                    rtse_pkg::CMD_LINEAR: n_state = rtse_pkg::S_LIN;
                    rtse_pkg::CMD_BINARY: n_state = rtse_pkg::S_BS_RD;
                    rtse_pkg::CMD_MAX: begin
                        n_state = w_empty ? rtse_pkg::S_DONE : rtse_pkg::S_MAX;
                    end
                    default: n_state = rtse_pkg::S_DONE;
                endcase
            end
            rtse_pkg::S_MOVE: begin
                if (w_walk_done) begin
                    n_state = rtse_pkg::S_DONE;
                end
            end
            rtse_pkg::S_LIN: begin
                if ((r_pend && w_key_eq) || w_walk_done) begin
                    n_state = rtse_pkg::S_DONE;
                end
            end
            rtse_pkg::S_BS_RD: begin
                n_state = w_lo_lt ? rtse_pkg::S_BS_CMP : rtse_pkg::S_DONE;
            end
            rtse_pkg::S_BS_CMP: begin
                n_state = w_key_eq ? rtse_pkg::S_DONE : rtse_pkg::S_BS_RD;
            end
            rtse_pkg::S_MAX: begin
                if (w_walk_done) begin
                    n_state = rtse_pkg::S_DONE;
                end
            end
            rtse_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = rtse_pkg::S_IDLE;
                end
            end
            default: n_state = rtse_pkg::S_IDLE;
        endcase
    end

    // datapath and store access
    always_comb begin
        n_count  = r_count;
        n_pend   = r_pend;
        n_first  = r_first;
        n_left   = r_left;
        n_ra     = r_ra;
        n_wa     = r_wa;
        n_pidx   = r_pidx;
        n_lo     = r_lo;
        n_hp1    = r_hp1;
        n_cmd    = r_cmd;
        n_new    = r_new;
        n_pos    = r_pos;
        n_status = r_status;
        n_ridx   = r_ridx;
        n_rrec   = r_rrec;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wa;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ra;

        case (r_state)
            rtse_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_item.cmd;
                    n_new.kh = i_item.kh;
                    n_new.kl = i_item.kl;
                    n_new.sc = w_sc_sat;
                    n_pos    = i_item.pos;
                end
            end
            rtse_pkg::S_DECODE: begin
                n_status = rtse_pkg::ST_OK;
                n_ridx   = '0;
                n_rrec   = '0;
                n_pend   = 1'b0;
                n_first  = 1'b0;
                case (r_cmd)
                    rtse_pkg::CMD_APPEND: begin
                        if (w_full) begin
                            n_status = rtse_pkg::ST_FULL;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = IW'(r_count);
                            o_mem_wdata = r_new;
                            n_ridx      = IW'(r_count);
                            n_rrec      = r_new;
                            n_count     = r_count + CW'(1);
                        end
                    end
                    rtse_pkg::CMD_INSERT: begin
                        if (w_pos_bad) begin
                            n_status = rtse_pkg::ST_BADPOS;
                        end else if (w_full) begin
                            n_status = rtse_pkg::ST_FULL;
                        end else begin
                            n_ra   = IW'(r_count - CW'(1));
                            n_left = r_count - CW'(w_pos_m1);
                        end
                    end
                    rtse_pkg::CMD_DELETE: begin
                        if (w_empty) begin
                            n_status = rtse_pkg::ST_EMPTY;
                        end else if (w_pos_bad) begin
                            n_status = rtse_pkg::ST_BADPOS;
                        end else begin
                            n_ra    = w_pos_m1;
                            n_left  = r_count - CW'(w_pos_m1);
                            n_first = 1'b1;
                            n_ridx  = w_pos_m1;
                        end
                    end
                    rtse_pkg::CMD_CLEAR: begin
                        n_count = '0;
                    end
                    rtse_pkg::CMD_LINEAR: begin
                        n_status = rtse_pkg::ST_NOTFOUND;
                        n_ra     = '0;
                        n_left   = r_count;
                    end
                    rtse_pkg::CMD_BINARY: begin
                        n_status = rtse_pkg::ST_NOTFOUND;
                        n_lo     = '0;
                        n_hp1    = r_count;
                    end
                    rtse_pkg::CMD_MAX: begin
                        if (w_empty) begin
                            n_status = rtse_pkg::ST_EMPTY;
                        end else begin
                            n_ra    = '0;
                            n_left  = r_count;
                            n_first = 1'b1;
                        end
                    end
                    default: begin
                        n_status = rtse_pkg::ST_OK;
                    end
                endcase
            end
            rtse_pkg::S_MOVE: begin
                if (r_pend) begin
                    if (r_first) begin
                        n_rrec  = i_mem_rdata;
                        n_first = 1'b0;
                    end else begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_wa;
                        o_mem_wdata = i_mem_rdata;
                    end
                end
                if (r_left != '0) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ra;
                    n_left      = r_left - CW'(1);
                    n_pend      = 1'b1;
                    if (r_cmd == rtse_pkg::CMD_INSERT) begin
                        n_wa = r_ra + IW'(1);
                        n_ra = r_ra - IW'(1);
                    end else begin
                        n_wa = r_ra - IW'(1);
                        n_ra = r_ra + IW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_cmd == rtse_pkg::CMD_INSERT) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = w_pos_m1;
                            o_mem_wdata = r_new;
                            n_ridx      = w_pos_m1;
                            n_rrec      = r_new;
                            n_count     = r_count + CW'(1);
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end
            rtse_pkg::S_LIN: begin
                if (r_pend && w_key_eq) begin
                    n_status = rtse_pkg::ST_OK;
                    n_ridx   = r_pidx;
                    n_rrec   = i_mem_rdata;
                    n_pend   = 1'b0;
                end else if (r_left != '0) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ra;
                    n_pidx      = r_ra;
                    n_ra        = r_ra + IW'(1);
                    n_left      = r_left - CW'(1);
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            rtse_pkg::S_BS_RD: begin
                if (w_lo_lt) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = w_mid;
                    n_pidx      = w_mid;
                end
            end
            rtse_pkg::S_BS_CMP: begin
                if (w_key_eq) begin
                    n_status = rtse_pkg::ST_OK;
                    n_ridx   = r_pidx;
                    n_rrec   = i_mem_rdata;
                end else if (w_key_gt) begin
                    n_hp1 = CW'(r_pidx);
                end else begin
                    n_lo = CW'(r_pidx) + CW'(1);
                end
            end
            rtse_pkg::S_MAX: begin
                if (r_pend) begin
                    n_first = 1'b0;
                    if (r_first || w_sc_gt) begin
                        n_rrec = i_mem_rdata;
                        n_ridx = r_pidx;
                    end
                end
                if (r_left != '0) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ra;
                    n_pidx      = r_ra;
                    n_ra        = r_ra + IW'(1);
                    n_left      = r_left - CW'(1);
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
    end

    // handshake and result
    always_comb begin
        o_ready                = (r_state == rtse_pkg::S_IDLE);
        o_done                 = (r_state == rtse_pkg::S_DONE) && i_out_free;
        o_result.status        = r_status;
        o_result.slot_index    = w_idx_ext[4:0];
        o_result.rec           = r_rrec;
        o_result.entry_count   = w_cnt_ext[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtse_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_left   <= n_left;
        r_ra     <= n_ra;
        r_wa     <= n_wa;
        r_pidx   <= n_pidx;
        r_lo     <= n_lo;
        r_hp1    <= n_hp1;
        r_cmd    <= n_cmd;
        r_new    <= n_new;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_ridx   <= n_ridx;
        r_rrec   <= n_rrec;
    end

endmodule

@@ sv/record_table_search_engine_top.sv @@
// ----------------------------------------------------------------------------
// record_table_search_engine_top
// Ordered record list with append, insert, delete, clear, linear and binary
// search and max-score scan, held in a single-port-write record store.
// One command in flight at a time; the next beat can be taken in the same
// cycle as the result beat is first presented. The store's one read per
// cycle sets the walk.
// Reset clears the record count and control; the store is not cleared.
// ----------------------------------------------------------------------------
module record_table_search_engine_top #(
    parameter int DEPTH = rtse_pkg::DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // key_high, key_low, score_in, position
    input  logic [2:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // slot_index, found_key_high, found_key_low,
                                    // found_score, entry_count, zero pad
    output logic [2:0]   m_tuser    // status
);

    localparam int IW = $clog2(DEPTH);

    rtse_pkg::t_item   w_item;
    rtse_pkg::t_result w_result;
    rtse_pkg::t_result r_mres;
    logic              r_mvalid;
    logic              w_out_free;
    logic              w_done;
    logic              w_mem_we;
    logic [IW-1:0]     w_mem_waddr;
    rtse_pkg::t_rec    w_mem_wdata;
    logic              w_mem_re;
    logic [IW-1:0]     w_mem_raddr;
    rtse_pkg::t_rec    w_mem_rdata;

    assign w_item.cmd = s_tuser;
    assign w_item.kh  = s_tdata[15:0];
    assign w_item.kl  = s_tdata[79:16];
    assign w_item.sc  = s_tdata[89:80];
    assign w_item.pos = s_tdata[95:90];

    assign w_out_free = !r_mvalid || m_tready;

    rtse_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_item      (w_item),
        .i_out_free  (w_out_free),
        .o_done      (w_done),
        .o_result    (w_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    rtse_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_done) begin
            r_mvalid <= 1'b1;
        end else if (m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_mres <= w_result;
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tuser  = r_mres.status;
    assign m_tdata  = {3'b000, r_mres.entry_count, r_mres.rec.sc, r_mres.rec.kl,
                       r_mres.rec.kh, r_mres.slot_index};

endmodule

@@ sim/record_table_checker.sv @@
// ----------------------------------------------------------------------------
// record_table_checker
// Watches both stream channels of the record table search engine. Every
// accepted command beat is run through a behavioural copy of the record
// list, and the result it should give is queued. Every accepted result beat
// is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module record_table_checker #(
    parameter int DEPTH = rtse_pkg::DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [95:0]  i_s_tdata,   // key_high, key_low, score_in, position
    input  logic [2:0]   i_s_tuser,   // cmd
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [103:0] i_m_tdata,   // slot_index, found_key_high, found_key_low,
                                      // found_score, entry_count, zero pad
    input  logic [2:0]   i_m_tuser,   // status
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked
);

    logic [79:0]       list_key [DEPTH];
    logic [9:0]        list_score [DEPTH];
    int                list_count;
    rtse_pkg::t_result expected_results [$];

    function automatic rtse_pkg::t_result record_at(int idx);
        rtse_pkg::t_result r;
        r = '0;
        r.status     = rtse_pkg::ST_OK;
        r.slot_index = 5'(idx);
        r.rec.kh     = list_key[idx][79:64];
        r.rec.kl     = list_key[idx][63:0];
        r.rec.sc     = list_score[idx];
        return r;
    endfunction

    function automatic rtse_pkg::t_result apply_command(logic [2:0] cmd, logic [79:0] key,
                                                        logic [9:0] score_in,
                                                        logic [5:0] pos);
        rtse_pkg::t_result r;
        logic [9:0]        sc;
        int                n, i, lo, hi, mid, best;
        bit                hit;
        r   = '0;
        sc  = (score_in > rtse_pkg::SCORE_MAX) ? rtse_pkg::SCORE_MAX : score_in;
        n   = list_count;
        hit = 1'b0;
        case (cmd)
            rtse_pkg::CMD_APPEND: begin
                if (n >= DEPTH) begin
                    r.status = rtse_pkg::ST_FULL;
                end else begin
                    list_key[n]   = key;
                    list_score[n] = sc;
                    r = record_at(n);
                    list_count = n + 1;
                end
            end
            rtse_pkg::CMD_INSERT: begin
                if (pos < 1 || pos > n) begin
                    r.status = rtse_pkg::ST_BADPOS;
                end else if (n >= DEPTH) begin
                    r.status = rtse_pkg::ST_FULL;
                end else begin
                    for (i = n; i >= pos; i--) begin
                        list_key[i]   = list_key[i - 1];
                        list_score[i] = list_score[i - 1];
                    end
                    list_key[pos - 1]   = key;
                    list_score[pos - 1] = sc;
                    r = record_at(pos - 1);
                    list_count = n + 1;
                end
            end
            rtse_pkg::CMD_DELETE: begin
                if (n == 0) begin
                    r.status = rtse_pkg::ST_EMPTY;
                end else if (pos < 1 || pos > n) begin
                    r.status = rtse_pkg::ST_BADPOS;
                end else begin
                    r = record_at(pos - 1);
                    for (i = pos - 1; i + 1 < n; i++) begin
                        list_key[i]   = list_key[i + 1];
                        list_score[i] = list_score[i + 1];
                    end
                    list_count = n - 1;
                end
            end
            rtse_pkg::CMD_CLEAR: list_count = 0;
            rtse_pkg::CMD_LINEAR: begin
                r.status = rtse_pkg::ST_NOTFOUND;
                for (i = 0; i < n && !hit; i++) begin
                    if (list_key[i] == key) begin
                        hit = 1'b1;
                        r = record_at(i);
                    end
                end
            end
            rtse_pkg::CMD_BINARY: begin
                r.status = rtse_pkg::ST_NOTFOUND;
                lo = 0;
                hi = n - 1;
                while (lo <= hi && !hit) begin
                    mid = (lo + hi) / 2;
                    if (list_key[mid] == key) begin
                        hit = 1'b1;
                        r = record_at(mid);
                    end else if (list_key[mid] > key) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            rtse_pkg::CMD_MAX: begin
                if (n == 0) begin
                    r.status = rtse_pkg::ST_EMPTY;
                end else begin
                    best = 0;
                    for (i = 1; i < n; i++)
                        if (list_score[i] > list_score[best])
                            best = i;
                    r = record_at(best);
                end
            end
            default: ;
        endcase
        r.entry_count = 6'(list_count);
        return r;
    endfunction

    function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        rtse_pkg::t_result want;
        if (!i_rst_n) begin
            list_count   = 0;
            expected_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // result first: a beat on the output always belongs to an older command
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    o_fail_count += field_diff("status", want.status, i_m_tuser);
                    o_fail_count += field_diff("slot_index", want.slot_index,
                                               i_m_tdata[4:0]);
                    o_fail_count += field_diff("found_key_high", want.rec.kh,
                                               i_m_tdata[20:5]);
                    o_fail_count += field_diff("found_key_low", want.rec.kl,
                                               i_m_tdata[84:21]);
                    o_fail_count += field_diff("found_score", want.rec.sc,
                                               i_m_tdata[94:85]);
                    o_fail_count += field_diff("entry_count", want.entry_count,
                                               i_m_tdata[100:95]);
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(apply_command(i_s_tuser,
                    {i_s_tdata[15:0], i_s_tdata[79:16]}, i_s_tdata[89:80],
                    i_s_tdata[95:90]));
        end
        o_pending = expected_results.size();
    end

endmodule

@@ sim/tb_record_table_search_engine_top.sv @@
// ----------------------------------------------------------------------------
// tb_record_table_search_engine_top
// Drives command beats into the record table search engine: a directed run
// over empty-list and invalid-position cases, then sorted-list builds with
// binary and linear lookups mixed with random command blocks. Both sides
// stall at random; the checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_record_table_search_engine_top;

    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         RANDOM_ITEMS = 800;
    localparam int         POOL_SIZE    = 40;
    localparam int         HOLD_CYCLES  = 300;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;

    int          fail_count;
    int          pending;
    int          checked;
    int          items_sent;
    int          cycles;
    int          sorted_builds;
    int          noise_blocks;
    bit          calm;
    logic [79:0] key_pool [POOL_SIZE];

    record_table_search_engine_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    record_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles", cycles);
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, one long hold-off once 200 commands are sent
    initial begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && items_sent >= 200) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    // called and returns at a falling edge; tvalid stays high unless a gap follows
    task automatic send_cmd(input logic [2:0] cmd, input logic [79:0] key,
                            input logic [9:0] score, input logic [5:0] pos);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pos, score, key[63:0], key[79:64]};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // pairs share key_high and differ in the top key_low bit, so the pool is sorted
    task automatic refresh_pool();
        int          i;
        logic [10:0] tail;
        tail = '0;
        for (i = 0; i < POOL_SIZE; i++) begin
            if (i % 2 == 0)
                tail = 11'($urandom);
            key_pool[i] = {5'(i / 2), tail, 1'(i % 2), 63'({$urandom, $urandom})};
        end
    endtask

    function automatic logic [79:0] random_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 80'({$urandom, $urandom, $urandom});
    endfunction

    function automatic logic [9:0] random_score();
        case ($urandom_range(0, 7))
            0: return 10'd0;
            1: return rtse_pkg::SCORE_MAX;
            2: return 10'h3FF;
            3: return 10'd500;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [5:0] random_pos();
        if ($urandom_range(0, 99) < 85)
            return 6'($urandom_range(0, 34));
        return 6'($urandom);
    endfunction

    function automatic logic [2:0] random_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return rtse_pkg::CMD_APPEND;
        if (roll < 42) return rtse_pkg::CMD_INSERT;
        if (roll < 54) return rtse_pkg::CMD_DELETE;
        if (roll < 56) return rtse_pkg::CMD_CLEAR;
        if (roll < 68) return rtse_pkg::CMD_LINEAR;
        if (roll < 78) return rtse_pkg::CMD_BINARY;
        if (roll < 92) return rtse_pkg::CMD_MAX;
        return CMD_UNUSED;
    endfunction

    task automatic directed_run();
        logic [79:0] key_mid;
        key_mid = 80'h8000_0123_4567_89AB_CDEF;
        send_cmd(rtse_pkg::CMD_DELETE, '0, 10'd0, 6'd1);
        send_cmd(rtse_pkg::CMD_MAX, '0, 10'd0, 6'd0);
        send_cmd(rtse_pkg::CMD_LINEAR, '1, 10'd0, 6'd0);
        send_cmd(rtse_pkg::CMD_BINARY, '1, 10'd0, 6'd0);
        send_cmd(rtse_pkg::CMD_INSERT, key_mid, 10'd5, 6'd1);
        send_cmd(rtse_pkg::CMD_APPEND, '1, 10'h3FF, 6'h3F);
        send_cmd(rtse_pkg::CMD_APPEND, '0, 10'd0, 6'd0);
        send_cmd(rtse_pkg::CMD_APPEND, key_mid, rtse_pkg::SCORE_MAX, 6'd0);
        send_cmd(rtse_pkg::CMD_MAX, '0, 10'd0, 6'd0);
        send_cmd(rtse_pkg::CMD_INSERT, key_mid, 10'd7, 6'd0);
        send_cmd(rtse_pkg::CMD_INSERT, key_mid, 10'd7, 6'h3F);
        send_cmd(rtse_pkg::CMD_INSERT, key_mid, 10'd7, 6'd4);
        send_cmd(rtse_pkg::CMD_INSERT, ~key_mid, 10'd1001, 6'd3);
        send_cmd(rtse_pkg::CMD_LINEAR, '0, 10'h3FF, 6'h3F);
        send_cmd(rtse_pkg::CMD_LINEAR, 80'h1, 10'd0, 6'd0);
        send_cmd(rtse_pkg::CMD_BINARY, key_mid, 10'd0, 6'd0);
        send_cmd(rtse_pkg::CMD_DELETE, '0, 10'd0, 6'd4);
        send_cmd(rtse_pkg::CMD_DELETE, '0, 10'd0, 6'd0);
        send_cmd(rtse_pkg::CMD_DELETE, '0, 10'd0, 6'd40);
        send_cmd(CMD_UNUSED, '1, 10'h3FF, 6'h3F);
        send_cmd(rtse_pkg::CMD_DELETE, '0, 10'd0, 6'd1);
        send_cmd(rtse_pkg::CMD_CLEAR, '1, 10'h3FF, 6'h3F);
        send_cmd(rtse_pkg::CMD_BINARY, '0, 10'd0, 6'd0);
    endtask

    // clear, append a sorted pool subset, maybe insert, then search, scan or delete
    task automatic sorted_build();
        int i, keep, lookups;
        refresh_pool();
        keep = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(5, 60);
        send_cmd(rtse_pkg::CMD_CLEAR, random_key(), random_score(), random_pos());
        for (i = 0; i < POOL_SIZE; i++)
            if ($urandom_range(1, 100) <= keep)
                send_cmd(rtse_pkg::CMD_APPEND, key_pool[i], random_score(), random_pos());
        if (keep == 100)
            send_cmd(rtse_pkg::CMD_INSERT, random_key(), random_score(),
                     6'($urandom_range(1, 32)));
        lookups = $urandom_range(6, 14);
        for (i = 0; i < lookups; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_cmd(rtse_pkg::CMD_BINARY, random_key(),
                                           random_score(), random_pos());
                6, 7:             send_cmd(rtse_pkg::CMD_LINEAR, random_key(),
                                           random_score(), random_pos());
                8:                send_cmd(rtse_pkg::CMD_MAX, random_key(),
                                           random_score(), random_pos());
                default:          send_cmd(rtse_pkg::CMD_DELETE, random_key(),
                                           random_score(), random_pos());
            endcase
        end
        sorted_builds++;
    endtask

    task automatic noise_block();
        int i, len;
        len = $urandom_range(8, 20);
        for (i = 0; i < len; i++)
            send_cmd(random_cmd(), random_key(), random_score(), random_pos());
        noise_blocks++;
    endtask

    initial begin
        int target;
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        calm          = 1'b0;
        items_sent    = 0;
        sorted_builds = 0;
        noise_blocks  = 0;
        refresh_pool();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_run();
        drain();

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            calm = (items_sent >= 350 && items_sent < 480);
            if ($urandom_range(0, 1) == 0)
                sorted_build();
            else
                noise_block();
            if ((sorted_builds + noise_blocks) % 5 == 4 &&
                (items_sent < 150 || items_sent > 260))
                drain();
        end
        calm = 1'b0;
        drain();
        repeat (80) @(posedge i_clk);

        $display("Sent %0d commands (%0d sorted-list builds, %0d random blocks)",
                 items_sent, sorted_builds, noise_blocks);
        $display("Compared %0d result beats in %0d cycles", checked, cycles);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
